>>> sv/masked_stack_mean_variance_assert.svh
// assertion macros for the masked stack mean and variance block
`ifndef MASKED_STACK_MEAN_VARIANCE_ASSERT_SVH
`define MASKED_STACK_MEAN_VARIANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define MMV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmv assertion failed");
`define MMV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmv assertion failed");
`else
`define MMV_ASSERT_IMP(lbl, ante, cons)
`define MMV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/mmv_pkg.sv
// package with widths, stack record and back end states
`default_nettype none
package mmv_pkg;
    localparam int MAX_FRAMES  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int VALUE_W = 16;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 40;
    localparam int USED_W  = 7;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int LOG_F  = $clog2(MAX_FRAMES);
    localparam int SUM_W  = SAMPLE_BITS + LOG_F;
    localparam int SQ_W   = 2 * SAMPLE_BITS + LOG_F;
    localparam int NUM_W  = CNT_W + SQ_W;
    localparam int DVD_W  = NUM_W + FRAC_BITS;
    localparam int DSR_W  = 2 * CNT_W;
    localparam int STEP_W = $clog2(DVD_W);

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] cnt;
    } t_stack;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SUB,
        B_DIV,
        B_OUT
    } t_bstate;
endpackage
`default_nettype wire

>>> sv/mmv_fifo.sv
// short queue of finished stack totals between front and back
`default_nettype none
module mmv_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mmv_pkg::t_stack i_data,
    input  wire logic           i_pop,
    output mmv_pkg::t_stack     o_data,
    output logic                o_full,
    output logic                o_empty
);
    import mmv_pkg::*;

    t_stack              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/mmv_front.sv
// front end: takes sample words and accumulates sum, sum of squares and count
`default_nettype none
module mmv_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [mmv_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                        i_sample_valid,
    input  wire logic                        i_last_frame,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output mmv_pkg::t_stack                  o_stack
);
    import mmv_pkg::*;

    logic [SUM_W-1:0]         r_sum, n_sum;
    logic [SQ_W-1:0]          r_sq, n_sq;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [SAMPLE_BITS-1:0]   w_val;
    logic [2*SAMPLE_BITS-1:0] w_sqv;
    logic                     w_use;
    logic                     w_acc;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_val   = i_sample_value[SAMPLE_BITS-1:0];
    assign w_sqv   = w_val * w_val;
    assign w_use   = i_sample_valid && (r_cnt < CNT_W'(MAX_FRAMES));

    always_comb begin
        n_sum = r_sum;
        n_sq  = r_sq;
        n_cnt = r_cnt;
        if (w_use) begin
            n_sum = r_sum + SUM_W'(w_val);
            n_sq  = r_sq + SQ_W'(w_sqv);
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_push      = w_acc && i_last_frame;
    assign o_stack.sum = n_sum;
    assign o_stack.sq  = n_sq;
    assign o_stack.cnt = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
        end else if (w_acc) begin
            if (i_last_frame) begin
                r_sum <= '0;
                r_sq  <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_sq  <= n_sq;
                r_cnt <= n_cnt;
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/mmv_back.sv
// back end: products, bit-serial divisions and the result register
`default_nettype none
module mmv_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire mmv_pkg::t_stack            i_stack,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [mmv_pkg::MEAN_W-1:0]      o_mean_scaled,
    output logic [mmv_pkg::VAR_W-1:0]       o_variance_scaled,
    output logic [mmv_pkg::USED_W-1:0]      o_used_count
);
    import mmv_pkg::*;

    t_bstate            r_state, n_state;
    logic [CNT_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_sum;
    logic [SQ_W-1:0]    r_sq;
    logic [NUM_W-1:0]   r_p1, r_p2;
    logic [CNT_W-1:0]   r_d_m;
    logic [DSR_W-1:0]   r_d_v;
    logic [DVD_W-1:0]   r_dvd_m, r_dvd_v;
    logic [CNT_W-1:0]   r_rem_m;
    logic [DSR_W-1:0]   r_rem_v;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    logic [MEAN_W-1:0]  r_mean;
    logic [VAR_W-1:0]   r_var;
    logic [USED_W-1:0]  r_used;

    logic [NUM_W-1:0]   w_p1, w_p2, w_num;
    logic [DSR_W-1:0]   w_dv;
    logic [CNT_W:0]     w_rsh_m, w_rnx_m;
    logic [DSR_W:0]     w_rsh_v, w_rnx_v;
    logic               w_ge_m, w_ge_v;
    logic               w_out_free;
    logic               w_load;

    assign w_p1  = r_n * r_sq;
    assign w_p2  = r_sum * r_sum;
    assign w_dv  = r_n * (r_n - 1'b1);
    assign w_num = r_p1 - r_p2;

    assign w_rsh_m = {r_rem_m, r_dvd_m[DVD_W-1]};
    assign w_ge_m  = (w_rsh_m >= {1'b0, r_d_m});
    assign w_rnx_m = w_ge_m ? (w_rsh_m - {1'b0, r_d_m}) : w_rsh_m;
    assign w_rsh_v = {r_rem_v, r_dvd_v[DVD_W-1]};
    assign w_ge_v  = (w_rsh_v >= {1'b0, r_d_v});
    assign w_rnx_v = w_ge_v ? (w_rsh_v - {1'b0, r_d_v}) : w_rsh_v;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_MUL;
            B_MUL:   n_state = B_SUB;
            B_SUB:   n_state = B_DIV;
            B_DIV:   if (r_step == '0) n_state = B_OUT;
            B_OUT:   if (w_out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            B_IDLE:  o_pop = !i_q_empty;
            B_OUT:   w_load = w_out_free;
            default: begin
                o_pop  = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_n   <= i_stack.cnt;
                    r_sum <= i_stack.sum;
                    r_sq  <= i_stack.sq;
                end
            end
            B_MUL: begin
                r_p1  <= w_p1;
                r_p2  <= w_p2;
                r_d_v <= w_dv;
                r_d_m <= r_n;
            end
            B_SUB: begin
                r_dvd_v <= DVD_W'(w_num) << FRAC_BITS;
                r_dvd_m <= DVD_W'(r_sum) << FRAC_BITS;
                r_rem_m <= '0;
                r_rem_v <= '0;
                r_step  <= STEP_W'(DVD_W - 1);
            end
            B_DIV: begin
                r_rem_m <= w_rnx_m[CNT_W-1:0];
                r_rem_v <= w_rnx_v[DSR_W-1:0];
                r_dvd_m <= {r_dvd_m[DVD_W-2:0], w_ge_m};
                r_dvd_v <= {r_dvd_v[DVD_W-2:0], w_ge_v};
                r_step  <= r_step - 1'b1;
            end
            B_OUT: begin
                if (w_load) begin
                    r_mean <= (r_n == '0) ? '0 : MEAN_W'(r_dvd_m);
                    r_var  <= (r_n < CNT_W'(2)) ? '0 : VAR_W'(r_dvd_v);
                    r_used <= USED_W'(r_n);
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_mean_scaled     = r_mean;
    assign o_variance_scaled = r_var;
    assign o_used_count      = r_used;
endmodule
`default_nettype wire

>>> sv/masked_stack_mean_variance.sv
// masked stack mean and variance: top level
// usage:
//   input channel i_valid/o_ready carries one sample word per frame of a pixel
//   stack: the value, a mask bit (i_sample_valid) and an end-of-stack mark.
//   output channel o_valid/i_ready carries one result word per stack: mean and
//   unbiased variance scaled by 2^8 and truncated, plus the count used.
//   the front takes one sample word every cycle while the stack queue has room
//   the back handles one stack at a time (multiply, subtract, then a 53-step
//   shared-counter restoring division for mean and variance side by side)
//   o_valid rises after that stack goes through the queue and B_IDLE to B_OUT
//   stacks no shorter than the back end's pass therefore stream at one word per cycle;
//   shorter stacks are paced by the back end through the two-entry queue
//   when the receiver stalls the result stays in its register, the back waits,
//   the queue fills and then o_ready drops
//   reset (synchronous, i_rst_n low) clears the accumulators, the queue and
//   the output valid; no clearing pass is needed
`default_nettype none
`include "masked_stack_mean_variance_assert.svh"
module masked_stack_mean_variance (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [mmv_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                        i_sample_valid,
    input  wire logic                        i_last_frame,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [mmv_pkg::MEAN_W-1:0]       o_mean_scaled,
    output logic [mmv_pkg::VAR_W-1:0]        o_variance_scaled,
    output logic [mmv_pkg::USED_W-1:0]       o_used_count
);
    import mmv_pkg::*;

    logic   w_push, w_pop, w_q_full, w_q_empty;
    t_stack w_push_data, w_pop_data;

    mmv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_value (i_sample_value),
        .i_sample_valid (i_sample_valid),
        .i_last_frame   (i_last_frame),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_stack        (w_push_data)
    );

    mmv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    mmv_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_stack           (w_pop_data),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_mean_scaled     (o_mean_scaled),
        .o_variance_scaled (o_variance_scaled),
        .o_used_count      (o_used_count)
    );

    `MMV_ASSERT_IMP(a_no_push_full, w_push, !w_q_full)
    `MMV_ASSERT_NXT(a_pop_spacing, w_pop, !w_pop)
    `MMV_ASSERT_IMP(a_count_max, o_valid, o_used_count <= USED_W'(MAX_FRAMES))
    `MMV_ASSERT_IMP(a_var_small_n, o_valid && (o_used_count < USED_W'(2)), o_variance_scaled == '0)
endmodule
`default_nettype wire

>>> verif/tb.sv
// testbench for masked_stack_mean_variance: random stacks against a mean and variance predictor
`timescale 1ns / 1ps
module tb;
    localparam int STACK_WORDS = 750;
    localparam int TAIL_CYCLES = 80;

    typedef struct {
        logic [mmv_pkg::MEAN_W-1:0] mean;
        logic [mmv_pkg::VAR_W-1:0]  variance;
        logic [mmv_pkg::USED_W-1:0] used;
    } t_stack_result;

    class stack_stats_board;
        logic [mmv_pkg::SUM_W-1:0] acc_sum;
        logic [mmv_pkg::SQ_W-1:0]  acc_sq;
        logic [mmv_pkg::CNT_W-1:0] acc_n;
        t_stack_result             expected_results[$];
        int                        fail_count;

        function new();
            acc_sum    = '0;
            acc_sq     = '0;
            acc_n      = '0;
            fail_count = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            fail_count++;
        endtask

        // accumulate one accepted word, close the stack on the last one
        function void note_word(logic [mmv_pkg::VALUE_W-1:0] value, logic use_it, logic last);
            bit [63:0]     v;
            bit [127:0]    wn;
            bit [127:0]    ws;
            bit [127:0]    wq;
            bit [127:0]    num;
            bit [63:0]     mean_full;
            bit [127:0]    var_full;
            t_stack_result res;
            v = 64'(value) & ((64'd1 << mmv_pkg::SAMPLE_BITS) - 64'd1);
            if (use_it && acc_n < mmv_pkg::MAX_FRAMES) begin
                acc_sum = acc_sum + mmv_pkg::SUM_W'(v);
                acc_sq  = acc_sq + mmv_pkg::SQ_W'(v * v);
                acc_n   = acc_n + 1'b1;
            end
            if (!last) return;
            mean_full = '0;
            var_full  = '0;
            if (acc_n == 1) begin
                mean_full = 64'(acc_sum) << mmv_pkg::FRAC_BITS;
            end else if (acc_n >= 2) begin
                wn        = 128'(acc_n);
                ws        = 128'(acc_sum);
                wq        = 128'(acc_sq);
                mean_full = (64'(acc_sum) << mmv_pkg::FRAC_BITS) / 64'(acc_n);
                num       = (wn * wq - ws * ws) << mmv_pkg::FRAC_BITS;
                var_full  = num / (wn * (wn - 128'd1));
            end
            res.mean     = mean_full[mmv_pkg::MEAN_W-1:0];
            res.variance = var_full[mmv_pkg::VAR_W-1:0];
            res.used     = mmv_pkg::USED_W'(acc_n);
            expected_results.push_back(res);
            acc_sum = '0;
            acc_sq  = '0;
            acc_n   = '0;
        endfunction

        task check_result(logic [mmv_pkg::MEAN_W-1:0] mean, logic [mmv_pkg::VAR_W-1:0] variance,
                          logic [mmv_pkg::USED_W-1:0] used);
            t_stack_result exp_res;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result mean=%0h var=%0h used=%0d",
                                 mean, variance, used));
                return;
            end
            exp_res = expected_results.pop_front();
            if (mean !== exp_res.mean)
                report($sformatf("mean %0h, want %0h", mean, exp_res.mean));
            if (variance !== exp_res.variance)
                report($sformatf("variance %0h, want %0h", variance, exp_res.variance));
            if (used !== exp_res.used)
                report($sformatf("used count %0d, want %0d", used, exp_res.used));
        endtask
    endclass

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_valid        = 1'b0;
    logic [mmv_pkg::VALUE_W-1:0] i_sample_value = '0;
    logic                        i_sample_valid = 1'b0;
    logic                        i_last_frame   = 1'b0;
    logic                        i_ready        = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic [mmv_pkg::MEAN_W-1:0]  o_mean_scaled;
    logic [mmv_pkg::VAR_W-1:0]   o_variance_scaled;
    logic [mmv_pkg::USED_W-1:0]  o_used_count;

    stack_stats_board sb;
    int burst_left  = 0;
    bit steady      = 1'b0;
    int words_sent  = 0;
    int stall_mode  = 0;
    int phase_left  = 0;
    int hold_left   = 0;

    masked_stack_mean_variance u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_value   (i_sample_value),
        .i_sample_valid   (i_sample_valid),
        .i_last_frame     (i_last_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mean_scaled    (o_mean_scaled),
        .o_variance_scaled(o_variance_scaled),
        .o_used_count     (o_used_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure: phases of always ready, random ready and long stalls
    always @(posedge i_clk) begin
        if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            phase_left = $urandom_range(50, 400);
        end else begin
            phase_left--;
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (hold_left != 0) begin
                    hold_left--;
                end else begin
                    i_ready   <= ~i_ready;
                    hold_left = i_ready ? $urandom_range(5, 100) : $urandom_range(1, 20);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_mean_scaled, o_variance_scaled, o_used_count);
    end

    task automatic idle_for(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            if (!steady)
                idle_for($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic send_word(logic [mmv_pkg::VALUE_W-1:0] value, logic use_it, logic last);
        pace();
        i_valid        <= 1'b1;
        i_sample_value <= value;
        i_sample_valid <= use_it;
        i_last_frame   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(value, use_it, last);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [mmv_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return mmv_pkg::VALUE_W'($urandom_range(0, 15));
            default: return mmv_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // mask_style: 0 all used, 1 all masked, otherwise mostly used
    task automatic send_stack(int len, int mask_style);
        logic use_it;
        for (int k = 0; k < len; k++) begin
            case (mask_style)
                0: use_it = 1'b1;
                1: use_it = 1'b0;
                default: use_it = ($urandom_range(0, 3) != 0);
            endcase
            send_word(pick_value(), use_it, k == len - 1);
        end
    endtask

    initial begin
        int len;
        int style_pick;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no used sample
        send_word(16'hffff, 1'b0, 1'b1);
        send_word(16'h1234, 1'b0, 1'b0);
        send_word(16'hffff, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b1);
        // single used sample
        send_word(16'hffff, 1'b1, 1'b1);
        send_word(16'h0000, 1'b1, 1'b1);
        // widest spread and equal pair
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'hffff, 1'b1, 1'b1);
        send_word(16'hffff, 1'b1, 1'b0);
        send_word(16'hffff, 1'b1, 1'b1);
        // masked word in the middle
        send_word(16'h0001, 1'b1, 1'b0);
        send_word(16'hffff, 1'b0, 1'b0);
        send_word(16'h0002, 1'b1, 1'b1);
        // last word masked
        send_word(16'hffff, 1'b1, 1'b0);
        send_word(16'hfffe, 1'b1, 1'b0);
        send_word(16'h8000, 1'b1, 1'b0);
        send_word(16'h7fff, 1'b0, 1'b1);
        send_word(16'h5555, 1'b1, 1'b0);
        send_word(16'haaaa, 1'b0, 1'b1);
        wait_drained();

        // count saturation: more used words than the stack can hold
        send_stack(70, 0);

        while (words_sent < STACK_WORDS) begin
            case ($urandom_range(0, 19))
                0: len = $urandom_range(57, 72);
                1, 2, 3: len = 1;
                default: len = $urandom_range(2, 16);
            endcase
            style_pick = $urandom_range(0, 9);
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            send_stack(len, (style_pick == 0) ? 1 : (style_pick < 5) ? 0 : 2);
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("** masked_stack_mean_variance: PASSED **");
        else
            $display("** masked_stack_mean_variance: FAILED **");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** masked_stack_mean_variance: FAILED **");
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/mmv_pkg.sv
sv/mmv_fifo.sv
sv/mmv_front.sv
sv/mmv_back.sv
sv/masked_stack_mean_variance.sv
verif/tb.sv
